### rtl/rpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the rotated two-plane pixel plotter.
package rpp_pkg;

  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int PLANE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;

  localparam int ADDR_W  = $clog2(PLANE_BYTES);
  localparam int SUM_W   = ADDR_W + 2;
  localparam int PX_W    = $clog2(MAX_WIDTH);
  localparam int PY_W    = $clog2(MAX_HEIGHT);
  localparam int RB_W    = $clog2(ROW_BYTES_MAX + 1);
  localparam int CFG_W   = 10;
  localparam int ROT_W   = 2;
  localparam int COORD_W = 16;
  localparam int PEN_W   = 2;
  localparam int IDX_W   = 2;

  localparam logic [7:0] BLACK_CLEAR = 8'hFF;
  localparam logic [7:0] RED_CLEAR   = 8'h00;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(400);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(300);
  localparam logic [ROT_W-1:0] ROT_RESET    = '0;

  localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_IDX_ROT    = IDX_W'(2);

  localparam logic [PEN_W-1:0] PEN_BLACK = PEN_W'(1);
  localparam logic [PEN_W-1:0] PEN_RED   = PEN_W'(2);

  localparam logic [ROT_W-1:0] ROT_0   = ROT_W'(0);
  localparam logic [ROT_W-1:0] ROT_90  = ROT_W'(1);
  localparam logic [ROT_W-1:0] ROT_180 = ROT_W'(2);
  localparam logic [ROT_W-1:0] ROT_270 = ROT_W'(3);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [PEN_W-1:0]          pen_color;
  } in_word_t;

  typedef struct packed {
    logic              written;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        black_byte;
    logic [7:0]        red_byte;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] panel_width;
    logic [CFG_W-1:0] panel_height;
    logic [ROT_W-1:0] rotation;
  } cfg_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic [PEN_W-1:0]  pen;
  } map_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        black;
    logic [7:0]        red;
  } plane_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_ADDR,
    ST_READ,
    ST_MOD
  } state_t;

endpackage

### rtl/rpp_map.sv
`timescale 1ns / 1ps
// Two-stage coordinate mapper: bounds check and rotation, then byte address.
module rpp_map (
  input  logic              clk,
  input  logic              ld_map,
  input  logic              ld_addr,
  input  rpp_pkg::in_word_t in_word,
  input  rpp_pkg::cfg_t     cfg,
  output rpp_pkg::map_t     map_res
);
  import rpp_pkg::*;

  logic [CFG_W-1:0]   w_c;
  logic [CFG_W-1:0]   h_c;
  logic [CFG_W-1:0]   lw;
  logic [CFG_W-1:0]   lh;
  logic [COORD_W-2:0] x_mag;
  logic [COORD_W-2:0] y_mag;
  logic               inb;
  logic [CFG_W-1:0]   w_m1_x;
  logic [CFG_W-1:0]   w_m1_y;
  logic [CFG_W-1:0]   h_m1_x;
  logic [CFG_W-1:0]   h_m1_y;
  logic [PX_W-1:0]    px;
  logic [PY_W-1:0]    py;
  logic [CFG_W:0]     rb_sum;

  logic [PX_W-1:0]    px_r;
  logic [PY_W-1:0]    py_r;
  logic               inb_r;
  logic [PEN_W-1:0]   pen_r;
  logic [RB_W-1:0]    row_bytes_r;

  logic [SUM_W-1:0]   addr_full;
  map_t               map_r;

  always_comb begin
    w_c = (cfg.panel_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg.panel_width;
    h_c = (cfg.panel_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg.panel_height;
    lw  = cfg.rotation[0] ? h_c : w_c;
    lh  = cfg.rotation[0] ? w_c : h_c;
    x_mag = in_word.x_coord[COORD_W-2:0];
    y_mag = in_word.y_coord[COORD_W-2:0];
    inb = !in_word.x_coord[COORD_W-1] && !in_word.y_coord[COORD_W-1] &&
          (x_mag < (COORD_W-1)'(lw)) && (y_mag < (COORD_W-1)'(lh));
    w_m1_x = w_c - CFG_W'(1) - x_mag[CFG_W-1:0];
    w_m1_y = w_c - CFG_W'(1) - y_mag[CFG_W-1:0];
    h_m1_x = h_c - CFG_W'(1) - x_mag[CFG_W-1:0];
    h_m1_y = h_c - CFG_W'(1) - y_mag[CFG_W-1:0];
    rb_sum = (CFG_W+1)'(w_c) + (CFG_W+1)'(7);
    unique case (cfg.rotation)
      ROT_90: begin
        px = w_m1_y[PX_W-1:0];
        py = x_mag[PY_W-1:0];
      end
      ROT_180: begin
        px = w_m1_x[PX_W-1:0];
        py = h_m1_y[PY_W-1:0];
      end
      ROT_270: begin
        px = y_mag[PX_W-1:0];
        py = h_m1_x[PY_W-1:0];
      end
      default: begin
        px = x_mag[PX_W-1:0];
        py = y_mag[PY_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_map) begin
      px_r        <= px;
      py_r        <= py;
      inb_r       <= inb;
      pen_r       <= in_word.pen_color;
      row_bytes_r <= RB_W'(rb_sum >> 3);
    end
  end

  assign addr_full = SUM_W'(py_r) * SUM_W'(row_bytes_r) + SUM_W'(px_r >> 3);

  always_ff @(posedge clk) begin
    if (ld_addr) begin
      map_r.ok      <= inb_r && (addr_full < SUM_W'(PLANE_BYTES));
      map_r.addr    <= addr_full[ADDR_W-1:0];
      map_r.bit_sel <= px_r[2:0];
      map_r.pen     <= pen_r;
    end
  end

  assign map_res = map_r;

endmodule

### rtl/rpp_planes.sv
`timescale 1ns / 1ps
// Black and red bit-plane memories with the clearing pass that follows reset.
module rpp_planes (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [rpp_pkg::ADDR_W-1:0]  rd_addr,
  input  rpp_pkg::plane_wr_t          wr_req,
  output logic [7:0]                  rd_black,
  output logic [7:0]                  rd_red,
  output logic                        clr_busy
);
  import rpp_pkg::*;

  logic [7:0] black_mem [PLANE_BYTES];
  logic [7:0] red_mem   [PLANE_BYTES];

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wblack;
  logic [7:0]        wred;
  logic [7:0]        rd_black_r;
  logic [7:0]        rd_red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(PLANE_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we     = clr_busy_r || wr_req.en;
    waddr  = clr_busy_r ? clr_addr_r : wr_req.addr;
    wblack = clr_busy_r ? BLACK_CLEAR : wr_req.black;
    wred   = clr_busy_r ? RED_CLEAR : wr_req.red;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      black_mem[waddr] <= wblack;
      red_mem[waddr]   <= wred;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_black_r <= black_mem[rd_addr];
      rd_red_r   <= red_mem[rd_addr];
    end
  end

  assign rd_black = rd_black_r;
  assign rd_red   = rd_red_r;
  assign clr_busy = clr_busy_r;

`ifndef ASSERT_OFF
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !wr_req.en && !rd_en)
    else $error("plane access during clearing pass");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == ADDR_W'(PLANE_BYTES - 1)))
    else $error("clearing pass ended before the last entry");
`endif

endmodule

### rtl/rotated_pixel_plot_two_plane.sv
`timescale 1ns / 1ps
// Top level of the rotated two-plane pixel plotter.
//
// A pixel word (x_coord, y_coord, pen_color) enters on the in_ channel and
// is taken at a clock edge where in_valid is high and in_stall is low. Each
// word yields exactly one result word on the out_ channel: written, the
// plane byte address and the new black and red bytes, or all zero when the
// point lies outside the rotated area.
// The block handles one word at a time: accept, map, address, memory read,
// then modify and write back. The result is registered as the modify step
// ends, and the next word is taken only after that. The pace is set by the
// single read-modify-write through the registered-read plane memories.
// After reset the planes are swept, black to 0xFF and red to 0x00, one byte
// a cycle over 32768 bytes; in_stall stays high throughout. Configuration
// writes on the cfg_ port are taken at any edge outside reset and belong
// between words, while no word is in flight.
// While out_stall holds, the result register keeps its word and the next
// word waits in the modify step until the register frees up.
module rotated_pixel_plot_two_plane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rpp_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rpp_pkg::out_word_t         out_word,
  input  logic                       cfg_we,
  input  logic [rpp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rpp_pkg::CFG_W-1:0]  cfg_data
);
  import rpp_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  cfg_t      cfg_r;
  in_word_t  in_r;
  map_t      map_res;
  plane_wr_t wr_req;
  out_word_t out_word_r;
  out_word_t out_word_nxt;
  logic      out_valid_r;
  logic      out_free;
  logic      plane_busy;
  logic      ld_map;
  logic      ld_addr;
  logic      rd_en;
  logic      mod_fire;
  logic [7:0] rd_black;
  logic [7:0] rd_red;
  logic [7:0] mask;
  logic [7:0] new_black;
  logic [7:0] new_red;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width  <= WIDTH_RESET;
      cfg_r.panel_height <= HEIGHT_RESET;
      cfg_r.rotation     <= ROT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  cfg_r.panel_width  <= cfg_data;
        CFG_IDX_HEIGHT: cfg_r.panel_height <= cfg_data;
        CFG_IDX_ROT:    cfg_r.rotation     <= cfg_data[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (!plane_busy) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MOD;
      ST_MOD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ld_map   = (state_r == ST_MAP);
    ld_addr  = (state_r == ST_ADDR);
    rd_en    = (state_r == ST_READ);
    mod_fire = (state_r == ST_MOD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_word;
    end
  end

  rpp_map u_map (
    .clk     (clk),
    .ld_map  (ld_map),
    .ld_addr (ld_addr),
    .in_word (in_r),
    .cfg     (cfg_r),
    .map_res (map_res)
  );

  rpp_planes u_planes (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (map_res.addr),
    .wr_req   (wr_req),
    .rd_black (rd_black),
    .rd_red   (rd_red),
    .clr_busy (plane_busy)
  );

  always_comb begin
    mask      = 8'h80 >> map_res.bit_sel;
    new_black = rd_black & ~mask;
    new_red   = rd_red & ~mask;
    unique case (map_res.pen)
      PEN_BLACK: new_black = new_black | mask;
      PEN_RED:   new_red   = new_red | mask;
      default: ;
    endcase
    wr_req.en    = mod_fire && map_res.ok;
    wr_req.addr  = map_res.addr;
    wr_req.black = new_black;
    wr_req.red   = new_red;
    out_word_nxt.written      = map_res.ok;
    out_word_nxt.byte_address = map_res.ok ? map_res.addr : '0;
    out_word_nxt.black_byte   = map_res.ok ? new_black : 8'h00;
    out_word_nxt.red_byte     = map_res.ok ? new_red : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mod_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    plane_busy |-> in_stall)
    else $error("input word taken while planes are being cleared");

  a_write_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> (map_res.ok && state_r == ST_MOD && out_free))
    else $error("plane write outside the modify step");

  a_drop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.written) |->
      (out_word_r.byte_address == '0 && out_word_r.black_byte == 8'h00 &&
       out_word_r.red_byte == 8'h00))
    else $error("dropped word carries nonzero fields");

  a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_MAP))
    else $error("accepted word did not enter the mapper");
`endif

endmodule
